FILE: src/lfp_pkg.sv
// shared constants, types and packing helper for the lidar frame parser
package lfp_pkg;

    localparam logic [7:0]  FRAME_HEADER       = 8'hFA;
    localparam logic [7:0]  EXPECTED_REG_RESET = 8'hE0;
    localparam logic [31:0] CRC_POLY           = 32'h04C11DB7;
    localparam logic [31:0] CRC_INIT           = 32'hFFFFFFFF;

    localparam int POS_W       = 5;
    localparam int OUT_TDATA_W = 136;

    typedef logic [POS_W-1:0] pos_t;

    localparam pos_t POS_HEADER    = 5'd0;
    localparam pos_t POS_REGISTER  = 5'd1;
    localparam pos_t POS_DIAG0     = 5'd2;
    localparam pos_t POS_DIAG1     = 5'd3;
    localparam pos_t POS_DIST_LO   = 5'd4;
    localparam pos_t POS_DIST_HI   = 5'd5;
    localparam pos_t POS_AMP_LO    = 5'd8;
    localparam pos_t POS_AMP_HI    = 5'd9;
    localparam pos_t POS_AMB_LO    = 5'd10;
    localparam pos_t POS_AMB_HI    = 5'd11;
    localparam pos_t POS_TOF_FIRST = 5'd12;
    localparam pos_t POS_CRC_B0    = 5'd20;
    localparam pos_t POS_CRC_B1    = 5'd21;
    localparam pos_t POS_CRC_B2    = 5'd22;
    localparam pos_t POS_LAST      = 5'd23;

    typedef struct packed {
        logic        crc_ok;
        logic [15:0] distance;
        logic [15:0] amplitude;
        logic [15:0] ambient;
        logic [7:0]  diag_first;
        logic [7:0]  diag_second;
        logic [63:0] tof_bytes;
    } lfp_result_t;

    function automatic logic [OUT_TDATA_W-1:0] pack_result(input lfp_result_t r);
        pack_result = {7'b0, r.tof_bytes, r.diag_second, r.diag_first,
                       r.ambient, r.amplitude, r.distance, r.crc_ok};
    endfunction

endpackage

FILE: src/lfp_crc_step.sv
// one byte of crc-32/mpeg-2, msb first, unrolled over eight bit steps
module lfp_crc_step (
    input  logic [31:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [31:0] crc_out
);
    import lfp_pkg::*;

    always_comb
    begin
        logic [31:0] c;
        c = crc_in ^ {data_in, 24'b0};
        for (int k = 0; k < 8; k++)
        begin
            if (c[31])
            begin
                c = {c[30:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[30:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

FILE: src/lfp_parser.sv
// frame position tracking, field capture and crc accumulation
module lfp_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    input  logic [7:0]          expected_register,
    output logic                res_valid,
    output lfp_pkg::lfp_result_t res,
    output lfp_pkg::pos_t       byte_pos
);
    import lfp_pkg::*;

    pos_t             pos_reg, pos_next;
    logic [31:0]      crc_reg, crc_next;
    logic [23:0]      rcv_reg, rcv_next;
    logic [15:0]      dist_reg, dist_next;
    logic [15:0]      amp_reg, amp_next;
    logic [15:0]      amb_reg, amb_next;
    logic [7:0]       diag0_reg, diag0_next;
    logic [7:0]       diag1_reg, diag1_next;
    logic [7:0][7:0]  tof_reg, tof_next;

    logic [31:0]      crc_seed;
    logic [31:0]      crc_upd;
    logic [2:0]       tof_idx;
    pos_t             pos_eff;

    // out-of-range positions behave as waiting for header
    assign pos_eff  = (pos_reg > POS_LAST) ? POS_HEADER : pos_reg;
    assign crc_seed = (pos_eff == POS_HEADER) ? CRC_INIT : crc_reg;
    assign tof_idx  = 3'(pos_eff - POS_TOF_FIRST);

    lfp_crc_step u_crc (
        .crc_in  (crc_seed),
        .data_in (rx_byte),
        .crc_out (crc_upd)
    );

    always_comb
    begin
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        rcv_next   = rcv_reg;
        dist_next  = dist_reg;
        amp_next   = amp_reg;
        amb_next   = amb_reg;
        diag0_next = diag0_reg;
        diag1_next = diag1_reg;
        tof_next   = tof_reg;
        if (step)
        begin
            if (pos_eff == POS_HEADER)
            begin
                if (rx_byte == FRAME_HEADER)
                begin
                    crc_next = crc_upd;
                    pos_next = POS_REGISTER;
                end
                else
                begin
                    pos_next = POS_HEADER;
                end
            end
            else if (pos_eff == POS_REGISTER)
            begin
                if (rx_byte == expected_register)
                begin
                    crc_next = crc_upd;
                    pos_next = POS_DIAG0;
                end
                else
                begin
                    pos_next = POS_HEADER;
                end
            end
            else if (pos_eff < POS_CRC_B0)
            begin
                crc_next = crc_upd;
                pos_next = pos_eff + 5'd1;
                case (pos_eff)
                    POS_DIAG0:   diag0_next = rx_byte;
                    POS_DIAG1:   diag1_next = rx_byte;
                    POS_DIST_LO: dist_next  = {8'b0, rx_byte};
                    POS_DIST_HI: dist_next  = {rx_byte, dist_reg[7:0]};
                    POS_AMP_LO:  amp_next   = {8'b0, rx_byte};
                    POS_AMP_HI:  amp_next   = {rx_byte, amp_reg[7:0]};
                    POS_AMB_LO:  amb_next   = {8'b0, rx_byte};
                    POS_AMB_HI:  amb_next   = {rx_byte, amb_reg[7:0]};
                    default:
                    begin
                        if (pos_eff >= POS_TOF_FIRST)
                        begin
                            tof_next[tof_idx] = rx_byte;
                        end
                    end
                endcase
            end
            else if (pos_eff == POS_CRC_B0)
            begin
                rcv_next = {16'b0, rx_byte};
                pos_next = POS_CRC_B1;
            end
            else if (pos_eff == POS_CRC_B1)
            begin
                rcv_next[15:8] = rx_byte;
                pos_next       = POS_CRC_B2;
            end
            else if (pos_eff == POS_CRC_B2)
            begin
                rcv_next[23:16] = rx_byte;
                pos_next        = POS_LAST;
            end
            else
            begin
                pos_next = POS_HEADER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_HEADER;
            crc_reg   <= CRC_INIT;
            rcv_reg   <= '0;
            dist_reg  <= '0;
            amp_reg   <= '0;
            amb_reg   <= '0;
            diag0_reg <= '0;
            diag1_reg <= '0;
            tof_reg   <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            rcv_reg   <= rcv_next;
            dist_reg  <= dist_next;
            amp_reg   <= amp_next;
            amb_reg   <= amb_next;
            diag0_reg <= diag0_next;
            diag1_reg <= diag1_next;
            tof_reg   <= tof_next;
        end
    end

    assign res_valid       = step && (pos_eff == POS_LAST);
    assign res.crc_ok      = ({rx_byte, rcv_reg} == crc_reg);
    assign res.distance    = dist_reg;
    assign res.amplitude   = amp_reg;
    assign res.ambient     = amb_reg;
    assign res.diag_first  = diag0_reg;
    assign res.diag_second = diag1_reg;
    assign res.tof_bytes   = tof_reg;
    assign byte_pos        = pos_reg;

endmodule

FILE: src/lfp_out_reg.sv
// result register on the master side
module lfp_out_reg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                res_valid,
    input  lfp_pkg::lfp_result_t                res,
    output logic                                slot_free,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lfp_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import lfp_pkg::*;

    logic                   valid_reg, valid_next;
    logic [OUT_TDATA_W-1:0] data_reg;

    assign slot_free  = !valid_reg || m_tready;
    assign valid_next = res_valid || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            data_reg <= pack_result(res);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

FILE: src/lidar_frame_parser_crc32_core.sv
// top level: input register, frame parser and result register
//
// Byte-stream parser for 24-byte lidar frames. Each accepted byte is held in
// an input register until the parser takes it. The parser then updates its
// frame position, captured fields and running CRC-32/MPEG-2. A frame starts
// on 0xFA, and its second byte must equal the configured register code.
// After byte 23, one result transaction carries the fields and the CRC match
// flag. A byte is accepted every cycle while the input is not stalled.
// m_tvalid rises once the last frame byte has passed from the input register
// through the parser into the output register. The input stalls only while a
// result waits in the output register and the input register is full.
// Write the register code only while no frame is in progress.
module lidar_frame_parser_crc32_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [7:0]                      cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // rx_byte[7:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // crc_ok[0], distance[16:1], amplitude[32:17], ambient[48:33],
    // diag_first[56:49], diag_second[64:57], tof_bytes[128:65], zero pad
    output logic [lfp_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import lfp_pkg::*;

    logic [7:0]  exp_code_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        slot_free;
    logic        step;
    logic        res_valid;
    lfp_result_t res;
    pos_t        byte_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_code_reg <= EXPECTED_REG_RESET;
        end
        else if (cfg_wr_en)
        begin
            exp_code_reg <= cfg_wr_data;
        end
    end

    // the held byte moves on whenever the result register can take a result
    assign step     = in_valid_reg && slot_free;
    assign s_tready = !in_valid_reg || slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    lfp_parser u_parser (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (step),
        .rx_byte           (in_byte_reg),
        .expected_register (exp_code_reg),
        .res_valid         (res_valid),
        .res               (res),
        .byte_pos          (byte_pos)
    );

    lfp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

`ifndef ASSERT_OFF
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_pos <= POS_LAST)
        else $error("frame position out of range");

    a_result_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (byte_pos == POS_HEADER) && m_tvalid)
        else $error("result did not close the frame");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && m_tvalid && !m_tready)
        else $error("input stalled without a waiting result");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(res_valid))
        else $error("result appeared without a finished frame");
`endif

endmodule

FILE: tb/tb_lidar_frame_parser_crc32_core.sv
// self-checking testbench for the lidar frame parser core with crc-32 check
`timescale 1ns / 100ps

module tb_lidar_frame_parser_crc32_core;
    import lfp_pkg::*;

    typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [7:0]             cfg_wr_data = 8'h00;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata     = 8'h00;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // stimulus and handshake bookkeeping
    logic [7:0] byte_queue[$];
    int         bytes_pushed   = 0;
    int         bytes_accepted = 0;
    bit         in_fire        = 1'b0;
    bit         idle_on        = 1'b1;
    bit         long_hold      = 1'b0;
    int         tx_idle_pct    = 0;
    int         rx_idle_pct    = 0;
    int         tx_gap         = 0;
    int         rx_gap         = 0;
    logic [7:0] phase_code     = EXPECTED_REG_RESET;
    int         err_count      = 0;
    int         result_count   = 0;

    // parser state as the checker sees it
    logic [7:0]  reg_code  = EXPECTED_REG_RESET;
    pos_t        frame_pos = POS_HEADER;
    logic [31:0] crc_acc   = CRC_INIT;
    logic [31:0] crc_rx    = '0;
    logic [15:0] dist_w    = '0;
    logic [15:0] amp_w     = '0;
    logic [15:0] amb_w     = '0;
    logic [7:0]  diag_b[2] = '{default: 8'h00};
    logic [7:0]  tof_b[8]  = '{default: 8'h00};
    lfp_result_t expected_frames[$];

    lidar_frame_parser_crc32_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // msb-first crc-32/mpeg-2 over one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h000000};
        for (int k = 0; k < 8; k++)
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    task automatic parse_byte(input logic [7:0] b);
        lfp_result_t r;
        int          sh;
        if (frame_pos > POS_LAST)
            frame_pos = POS_HEADER;
        if (frame_pos == POS_HEADER)
        begin
            if (b == FRAME_HEADER)
            begin
                crc_acc   = crc_byte(CRC_INIT, b);
                frame_pos = POS_REGISTER;
            end
        end
        else if (frame_pos == POS_REGISTER)
        begin
            if (b == reg_code)
            begin
                crc_acc   = crc_byte(crc_acc, b);
                frame_pos = POS_DIAG0;
            end
            else
                frame_pos = POS_HEADER;
        end
        else if (frame_pos < POS_CRC_B0)
        begin
            crc_acc = crc_byte(crc_acc, b);
            case (frame_pos)
                POS_DIAG0:   diag_b[0] = b;
                POS_DIAG1:   diag_b[1] = b;
                POS_DIST_LO: dist_w = {8'h00, b};
                POS_DIST_HI: dist_w[15:8] = b;
                POS_AMP_LO:  amp_w = {8'h00, b};
                POS_AMP_HI:  amp_w[15:8] = b;
                POS_AMB_LO:  amb_w = {8'h00, b};
                POS_AMB_HI:  amb_w[15:8] = b;
                default:
                begin
                    // bytes 6 and 7 only go into the crc
                    if (frame_pos >= POS_TOF_FIRST)
                        tof_b[frame_pos - POS_TOF_FIRST] = b;
                end
            endcase
            frame_pos = frame_pos + 1'b1;
        end
        else if (frame_pos == POS_CRC_B0)
        begin
            crc_rx    = {24'h000000, b};
            frame_pos = POS_CRC_B1;
        end
        else if (frame_pos < POS_LAST)
        begin
            sh                 = 8 * int'(frame_pos - POS_CRC_B0);
            crc_rx[sh +: 8]    = b;
            frame_pos          = frame_pos + 1'b1;
        end
        else
        begin
            crc_rx[31:24]  = b;
            r.crc_ok       = (crc_rx == crc_acc);
            r.distance     = dist_w;
            r.amplitude    = amp_w;
            r.ambient      = amb_w;
            r.diag_first   = diag_b[0];
            r.diag_second  = diag_b[1];
            for (int k = 0; k < 8; k++)
                r.tof_bytes[8*k +: 8] = tof_b[k];
            expected_frames.push_back(r);
            frame_pos = POS_HEADER;
        end
    endtask

    // register writes, input transactions and result checks, all on the rising edge
    always @(posedge clk)
    begin : scoreboard
        lfp_result_t got;
        lfp_result_t want;
        bit          bad;
        in_fire = rst_n && s_tvalid && s_tready;
        if (rst_n && cfg_wr_en)
            reg_code = cfg_wr_data;
        if (in_fire)
        begin
            bytes_accepted++;
            parse_byte(s_tdata);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got.crc_ok      = m_tdata[0];
            got.distance    = m_tdata[16:1];
            got.amplitude   = m_tdata[32:17];
            got.ambient     = m_tdata[48:33];
            got.diag_first  = m_tdata[56:49];
            got.diag_second = m_tdata[64:57];
            got.tof_bytes   = m_tdata[128:65];
            result_count++;
            if (expected_frames.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result transaction %0d: %h", result_count, m_tdata);
            end
            else
            begin
                want = expected_frames.pop_front();
                bad  = (got.crc_ok !== want.crc_ok) || (got.distance !== want.distance)
                    || (got.amplitude !== want.amplitude) || (got.ambient !== want.ambient)
                    || (got.diag_first !== want.diag_first)
                    || (got.diag_second !== want.diag_second)
                    || (got.tof_bytes !== want.tof_bytes);
                if (bad)
                begin
                    err_count++;
                    if (err_count <= 10)
                    begin
                        $display("mismatch on result %0d (exp / act):", result_count);
                        $display("  crc_ok %0b / %0b  distance %h / %h  amplitude %h / %h",
                                 want.crc_ok, got.crc_ok, want.distance, got.distance,
                                 want.amplitude, got.amplitude);
                        $display("  ambient %h / %h  diag %h %h / %h %h",
                                 want.ambient, got.ambient, want.diag_first,
                                 want.diag_second, got.diag_first, got.diag_second);
                        $display("  tof %h / %h", want.tof_bytes, got.tof_bytes);
                    end
                end
            end
        end
    end

    // byte sender
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_fire))
        begin
            if (tx_gap != 0)
            begin
                tx_gap   <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (byte_queue.size() != 0 && idle_on
                     && $urandom_range(0, 99) < tx_idle_pct)
            begin
                tx_gap   <= $urandom_range(0, 12);
                s_tvalid <= 1'b0;
            end
            else if (byte_queue.size() != 0)
            begin
                s_tdata  <= byte_queue.pop_front();
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold)
                m_tready <= 1'b0;
            else if (rx_gap != 0)
            begin
                rx_gap   <= rx_gap - 1;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 99) < rx_idle_pct)
            begin
                rx_gap   <= $urandom_range(0, 12);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        byte_queue.push_back(b);
        bytes_pushed++;
    endtask

    task automatic push_frame(input logic [7:0] code, input fill_t fill, input bit spoil);
        logic [7:0]  fr[24];
        logic [31:0] c;
        fr[0] = FRAME_HEADER;
        fr[1] = code;
        for (int i = 2; i < 20; i++)
        begin
            case (fill)
                FILL_ONES:  fr[i] = 8'hFF;
                FILL_ZEROS: fr[i] = 8'h00;
                default:    fr[i] = ($urandom_range(0, 7) == 0) ? FRAME_HEADER
                                                                : 8'($urandom_range(0, 255));
            endcase
        end
        c = CRC_INIT;
        for (int i = 0; i < 20; i++)
            c = crc_byte(c, fr[i]);
        for (int i = 0; i < 4; i++)
            fr[20 + i] = c[8*i +: 8];
        // single bit error somewhere in the trailing crc
        if (spoil)
            fr[20 + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
        foreach (fr[i])
            push_byte(fr[i]);
    endtask

    // mostly good frames, plus noise, bad register codes and cut-off frames
    task automatic run_random(input int n);
        int         useful;
        int         pick;
        int         len;
        logic [7:0] x;
        useful = 0;
        while (useful < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 66)
            begin
                push_frame(phase_code, FILL_RANDOM, $urandom_range(0, 5) == 0);
                useful += 24;
            end
            else if (pick < 70)
            begin
                push_frame(phase_code, pick[0] ? FILL_ONES : FILL_ZEROS,
                           $urandom_range(0, 3) == 0);
                useful += 24;
            end
            else if (pick < 80)
                repeat ($urandom_range(1, 6)) push_byte($urandom_range(0, 255));
            else if (pick < 90)
            begin
                x = $urandom_range(1, 255);
                push_byte(FRAME_HEADER);
                push_byte(phase_code ^ x);
                useful += 2;
            end
            else
            begin
                len = $urandom_range(1, 20);
                push_byte(FRAME_HEADER);
                push_byte(phase_code);
                repeat (len) push_byte($urandom_range(0, 255));
                useful += len + 2;
            end
        end
    endtask

    task automatic wait_accepted();
        while (bytes_accepted != bytes_pushed)
            @(negedge clk);
    endtask

    // finish any open frame, collect every result and let the pipeline drain
    task automatic settle();
        wait_accepted();
        while (frame_pos != POS_HEADER)
        begin
            if (frame_pos == POS_REGISTER)
                push_byte(~reg_code);
            else
                push_byte($urandom_range(0, 255));
            wait_accepted();
        end
        while (expected_frames.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_code(input logic [7:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        phase_code  = v;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset register code, directed cases first
        tx_idle_pct = 10;
        rx_idle_pct = 10;
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'hF9);
        push_byte(FRAME_HEADER);
        push_byte(8'h00);
        // second header byte is a register mismatch, not a new start
        push_byte(FRAME_HEADER);
        push_byte(FRAME_HEADER);
        push_frame(phase_code, FILL_ONES, 1'b0);
        push_frame(phase_code, FILL_ZEROS, 1'b1);
        run_random(250);
        settle();

        // receiver holds off while the sender keeps going
        write_code(8'h00);
        tx_idle_pct = 0;
        rx_idle_pct = 5;
        push_frame(8'h00, FILL_ZEROS, 1'b0);
        run_random(350);
        repeat (40) @(posedge clk);
        long_hold = 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
        settle();

        write_code(8'hFF);
        tx_idle_pct = $urandom_range(0, 25);
        rx_idle_pct = $urandom_range(0, 25);
        run_random(350);
        settle();

        // register code equal to the header byte
        write_code(FRAME_HEADER);
        tx_idle_pct = $urandom_range(0, 15);
        rx_idle_pct = $urandom_range(10, 30);
        push_frame(FRAME_HEADER, FILL_RANDOM, 1'b0);
        run_random(300);
        settle();

        write_code($urandom_range(1, 254));
        tx_idle_pct = $urandom_range(5, 30);
        rx_idle_pct = $urandom_range(0, 10);
        run_random(250);
        settle();

        write_code(EXPECTED_REG_RESET);
        idle_on = 1'b0;
        run_random(250);
        settle();

        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
